[rtl/bb3_pkg.sv]
// bb3_pkg: shared constants, types and the reciprocal table for the 3x3 RGB box blur.
// No dependencies; used by every file of the block except the pixel channel interfaces.
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // configuration register fields
    localparam int FW_FIELD_W = 11;
    localparam int FH_FIELD_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (FW_FIELD_W > FH_FIELD_W) ? FW_FIELD_W : FH_FIELD_W;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // counter and dimension widths
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int OROW_W   = $clog2(MAX_HEIGHT);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);

    localparam int RESET_WIDTH  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RESET_HEIGHT = 1;

    // arithmetic widths
    localparam int SUM_W       = $clog2(9 * 255 + 1);
    localparam int NUM_W       = SUM_W + 1;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = NUM_W + 5;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int PROD_W      = NUM_W + RECIP_W;

    // ceil(2^K / (2*count)): exact floor division of numerators below 2^NUM_W
    localparam int RECIP_1 = (2 ** RECIP_SHIFT + 2 - 1) / 2;
    localparam int RECIP_2 = (2 ** RECIP_SHIFT + 4 - 1) / 4;
    localparam int RECIP_3 = (2 ** RECIP_SHIFT + 6 - 1) / 6;
    localparam int RECIP_4 = (2 ** RECIP_SHIFT + 8 - 1) / 8;
    localparam int RECIP_6 = (2 ** RECIP_SHIFT + 12 - 1) / 12;
    localparam int RECIP_9 = (2 ** RECIP_SHIFT + 18 - 1) / 18;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // index 0 = upper row, 1 = middle row, 2 = lower row
    typedef pixel_t [2:0] column_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t middle;
    } line_t;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        pixel_t           pix;
        logic             emit;
        logic             top;
        logic             bot;
        logic             lft;
        logic             rgt;
        logic             last;
    } s1_t;

    typedef struct packed {
        logic             valid;
        logic [NUM_W-1:0] num_r;
        logic [NUM_W-1:0] num_g;
        logic [NUM_W-1:0] num_b;
        logic [CNT_W-1:0] count;
        logic             last;
    } s2_t;

    function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] m;
        case (count)
            CNT_W'(1): m = RECIP_W'(RECIP_1);
            CNT_W'(2): m = RECIP_W'(RECIP_2);
            CNT_W'(3): m = RECIP_W'(RECIP_3);
            CNT_W'(4): m = RECIP_W'(RECIP_4);
            CNT_W'(6): m = RECIP_W'(RECIP_6);
            CNT_W'(9): m = RECIP_W'(RECIP_9);
            default:   m = '0;
        endcase
        return m;
    endfunction

endpackage

[rtl/bb3_in_if.sv]
// bb3_in_if: pixel input channel (valid/ready plus mode and RGB payload).
// Depends on nothing.
interface bb3_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;

    modport source (output valid, output mode, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink   (input valid, input mode, input in_red, input in_green,
                    input in_blue, output ready);
endinterface

[rtl/bb3_out_if.sv]
// bb3_out_if: blurred pixel output channel (valid/ready plus RGB and end-of-frame flag).
// Depends on nothing.
interface bb3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_frame;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output last_of_frame, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input last_of_frame, output ready);
endinterface

[rtl/bb3_cfg_if.sv]
// bb3_cfg_if: configuration write channel (valid/ready, register index, write data).
// Depends on bb3_pkg for field widths.
interface bb3_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bb3_pkg::CFG_IDX_W-1:0]  index;
    logic [bb3_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/box_blur_3x3_rgb.sv]
// box_blur_3x3_rgb: top level of the 3x3 RGB box blur.
// Depends on bb3_pkg, the three channel interfaces, bb3_line_store, bb3_window, bb3_divide.
//
// Usage:
//   pix_in  : raster-order pixels, mode 0 = pixel, mode 1 = drain transaction.
//   pix_out : one blurred pixel per result, last_of_frame on the final one.
//   cfg     : index 0 = frame_width (1..1024), index 1 = frame_height (1..4096);
//             a write to either also restarts the frame. Write only while the block is idle.
// Each output pixel is the half-up rounded mean of the in-frame 3x3 neighbours.
// Results lag the input by frame_width+1 transactions; after the last pixel send
// frame_width+1 drain transactions to flush the frame. Drain transactions inside a
// frame are accepted and dropped.
// Throughput: one transaction per clock while the output is not stalled. A result is
// registered after the edge that accepts the transaction releasing it: the accepting
// edge issues the line-store read, then the window/sum stage, then the divide stage.
// The line-store RAM takes one read and one write per clock, which sets that rate.
// When the receiver stalls, the output register holds and the whole pipe stops;
// pix_in.ready drops until the pending result is taken.
// Reset: position counters clear, frame_width = 1024, frame_height = 1. The line
// stores are not cleared; an entry is always written before it is used.
module box_blur_3x3_rgb (
    input  logic      clk,
    input  logic      rst_n,
    bb3_cfg_if.sink   cfg,
    bb3_in_if.sink    pix_in,
    bb3_out_if.source pix_out
);

    logic [bb3_pkg::WIDTH_W-1:0]  frame_width_reg;
    logic [bb3_pkg::WIDTH_W-1:0]  frame_width_next;
    logic [bb3_pkg::HEIGHT_W-1:0] frame_height_reg;
    logic [bb3_pkg::HEIGHT_W-1:0] frame_height_next;
    logic [bb3_pkg::ROW_W-1:0]    in_row_reg;
    logic [bb3_pkg::ROW_W-1:0]    in_row_next;
    logic [bb3_pkg::COL_W-1:0]    in_col_reg;
    logic [bb3_pkg::COL_W-1:0]    in_col_next;
    logic [bb3_pkg::OROW_W-1:0]   out_row_reg;
    logic [bb3_pkg::OROW_W-1:0]   out_row_next;
    logic [bb3_pkg::COL_W-1:0]    out_col_reg;
    logic [bb3_pkg::COL_W-1:0]    out_col_next;
    bb3_pkg::s1_t                 s1_reg;
    bb3_pkg::s1_t                 s1_next;

    logic            en;
    logic            accept;
    logic            draining;
    logic            enter;
    logic            emit;
    logic            top_f;
    logic            bot_f;
    logic            lft_f;
    logic            rgt_f;
    logic            last_f;
    logic            in_wrap;
    logic            out_wrap;
    logic            cfg_we;
    bb3_pkg::pixel_t pix;

    bb3_pkg::line_t              line_q;
    logic                        wr_en;
    logic [bb3_pkg::COL_W-1:0]   wr_addr;
    bb3_pkg::line_t              wr_data;
    bb3_pkg::s2_t                s2;
    logic                        out_valid;
    bb3_pkg::pixel_t             out_pix;
    logic                        out_last;

    function automatic logic [bb3_pkg::WIDTH_W-1:0] clamp_width(
        logic [bb3_pkg::FW_FIELD_W-1:0] v);
        logic [bb3_pkg::WIDTH_W-1:0] r;
        if (v == '0)
            r = bb3_pkg::WIDTH_W'(1);
        else if (int'(v) > bb3_pkg::MAX_WIDTH)
            r = bb3_pkg::WIDTH_W'(bb3_pkg::MAX_WIDTH);
        else
            r = bb3_pkg::WIDTH_W'(v);
        return r;
    endfunction

    function automatic logic [bb3_pkg::HEIGHT_W-1:0] clamp_height(
        logic [bb3_pkg::FH_FIELD_W-1:0] v);
        logic [bb3_pkg::HEIGHT_W-1:0] r;
        if (v == '0)
            r = bb3_pkg::HEIGHT_W'(1);
        else if (int'(v) > bb3_pkg::MAX_HEIGHT)
            r = bb3_pkg::HEIGHT_W'(bb3_pkg::MAX_HEIGHT);
        else
            r = bb3_pkg::HEIGHT_W'(v);
        return r;
    endfunction

    assign en           = !out_valid || pix_out.ready;
    assign pix_in.ready = en;
    assign cfg.ready    = 1'b1;
    assign cfg_we       = cfg.valid && cfg.ready;

    assign accept   = pix_in.valid && en;
    assign draining = in_row_reg >= bb3_pkg::ROW_W'(frame_height_reg);
    // drain transactions inside the frame are dropped
    assign enter    = accept && !(pix_in.mode && !draining);
    assign pix      = draining ? '0 : {pix_in.in_red, pix_in.in_green, pix_in.in_blue};

    // a result is due once a full row plus one pixel has come in
    assign emit  = (in_row_reg >= bb3_pkg::ROW_W'(2)) ||
                   ((in_row_reg == bb3_pkg::ROW_W'(1)) && (in_col_reg != '0));
    assign top_f = out_row_reg != '0;
    assign bot_f = (bb3_pkg::HEIGHT_W'(out_row_reg) + bb3_pkg::HEIGHT_W'(1)) < frame_height_reg;
    assign lft_f = out_col_reg != '0;
    assign rgt_f = (bb3_pkg::WIDTH_W'(out_col_reg) + bb3_pkg::WIDTH_W'(1)) < frame_width_reg;
    assign last_f = emit &&
        (bb3_pkg::HEIGHT_W'(out_row_reg) == frame_height_reg - bb3_pkg::HEIGHT_W'(1)) &&
        (bb3_pkg::WIDTH_W'(out_col_reg) == frame_width_reg - bb3_pkg::WIDTH_W'(1));
    assign in_wrap  = (bb3_pkg::WIDTH_W'(in_col_reg) + bb3_pkg::WIDTH_W'(1)) >= frame_width_reg;
    assign out_wrap = !rgt_f;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_row_next       = in_row_reg;
        in_col_next       = in_col_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        if (cfg_we)
        begin
            case (cfg.index)
                bb3_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_next = clamp_width(cfg.data[bb3_pkg::FW_FIELD_W-1:0]);
                    in_row_next      = '0;
                    in_col_next      = '0;
                    out_row_next     = '0;
                    out_col_next     = '0;
                end
                bb3_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_next = clamp_height(cfg.data[bb3_pkg::FH_FIELD_W-1:0]);
                    in_row_next       = '0;
                    in_col_next       = '0;
                    out_row_next      = '0;
                    out_col_next      = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (enter)
        begin
            if (last_f)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
            end
            else
            begin
                if (in_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + bb3_pkg::ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + bb3_pkg::COL_W'(1);
                end
                if (emit)
                begin
                    if (out_wrap)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + bb3_pkg::OROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_reg + bb3_pkg::COL_W'(1);
                    end
                end
            end
        end
    end

    always_comb
    begin
        s1_next = s1_reg;
        if (en)
        begin
            s1_next.valid = enter;
            s1_next.col   = in_col_reg;
            s1_next.pix   = pix;
            s1_next.emit  = emit;
            s1_next.top   = top_f;
            s1_next.bot   = bot_f;
            s1_next.lft   = lft_f;
            s1_next.rgt   = rgt_f;
            s1_next.last  = last_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bb3_pkg::WIDTH_W'(bb3_pkg::RESET_WIDTH);
            frame_height_reg <= bb3_pkg::HEIGHT_W'(bb3_pkg::RESET_HEIGHT);
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            s1_reg           <= '0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_row_reg       <= in_row_next;
            in_col_reg       <= in_col_next;
            out_row_reg      <= out_row_next;
            out_col_reg      <= out_col_next;
            s1_reg           <= s1_next;
        end
    end

    bb3_line_store u_line_store (
        .clk     (clk),
        .rd_en   (enter),
        .rd_addr (in_col_reg),
        .rd_data (line_q),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    bb3_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .rd_en   (enter),
        .rd_addr (in_col_reg),
        .s1      (s1_reg),
        .line_q  (line_q),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .s2      (s2)
    );

    bb3_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .s2        (s2),
        .out_valid (out_valid),
        .out_pix   (out_pix),
        .out_last  (out_last)
    );

    assign pix_out.valid         = out_valid;
    assign pix_out.out_red       = out_pix.red;
    assign pix_out.out_green     = out_pix.green;
    assign pix_out.out_blue      = out_pix.blue;
    assign pix_out.last_of_frame = out_last;

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (bb3_pkg::WIDTH_W'(in_col_reg) < frame_width_reg) &&
        (bb3_pkg::WIDTH_W'(out_col_reg) < frame_width_reg))
        else $error("column counter beyond frame width");

    a_out_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        bb3_pkg::HEIGHT_W'(out_row_reg) < frame_height_reg)
        else $error("output row beyond frame height");

endmodule

[rtl/bb3_line_store.sv]
// bb3_line_store: the two line stores packed side by side in one synchronous RAM.
// One write and one registered read per cycle. Depends on bb3_pkg.
module bb3_line_store (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [bb3_pkg::COL_W-1:0] rd_addr,
    output bb3_pkg::line_t            rd_data,
    input  logic                      wr_en,
    input  logic [bb3_pkg::COL_W-1:0] wr_addr,
    input  bb3_pkg::line_t            wr_data
);

    bb3_pkg::line_t mem [bb3_pkg::MAX_WIDTH];
    bb3_pkg::line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write; same-cycle collisions are forwarded by the window stage
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bb3_window.sv]
// bb3_window: window stage. Merges line-store data (with write forwarding), updates the
// column window, writes the line stores back and forms the rounding numerators.
// Depends on bb3_pkg.
module bb3_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      rd_en,
    input  logic [bb3_pkg::COL_W-1:0] rd_addr,
    input  bb3_pkg::s1_t              s1,
    input  bb3_pkg::line_t            line_q,
    output logic                      wr_en,
    output logic [bb3_pkg::COL_W-1:0] wr_addr,
    output bb3_pkg::line_t            wr_data,
    output bb3_pkg::s2_t              s2
);

    bb3_pkg::column_t col0_reg;
    bb3_pkg::column_t col1_reg;
    bb3_pkg::column_t col2;
    logic             fwd_valid_reg;
    logic             fwd_valid_next;
    bb3_pkg::line_t   fwd_data_reg;
    bb3_pkg::line_t   line_eff;
    bb3_pkg::s2_t     s2_reg;
    bb3_pkg::s2_t     s2_next;

    logic [bb3_pkg::SUM_W-1:0] sum_r;
    logic [bb3_pkg::SUM_W-1:0] sum_g;
    logic [bb3_pkg::SUM_W-1:0] sum_b;
    logic [1:0]                row_n;
    logic [1:0]                col_n;
    logic [bb3_pkg::CNT_W-1:0] cnt;
    logic [2:0]                kmask;
    logic [2:0]                rmask;
    bb3_pkg::column_t          cols [3];

    assign line_eff = fwd_valid_reg ? fwd_data_reg : line_q;

    always_comb
    begin
        col2[0] = line_eff.upper;
        col2[1] = line_eff.middle;
        col2[2] = s1.pix;
    end

    assign wr_en          = en && s1.valid;
    assign wr_addr        = s1.col;
    assign wr_data.upper  = line_eff.middle;
    assign wr_data.middle = s1.pix;

    // a read issued in the same cycle as a write to that entry gets the new data here
    assign fwd_valid_next = rd_en && s1.valid && (rd_addr == s1.col);

    always_comb
    begin
        cols[0] = col0_reg;
        cols[1] = col1_reg;
        cols[2] = col2;
        kmask   = {s1.rgt, 1'b1, s1.lft};
        rmask   = {s1.bot, 1'b1, s1.top};
        sum_r   = '0;
        sum_g   = '0;
        sum_b   = '0;
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (kmask[k] && rmask[r])
                begin
                    sum_r = sum_r + bb3_pkg::SUM_W'(cols[k][r].red);
                    sum_g = sum_g + bb3_pkg::SUM_W'(cols[k][r].green);
                    sum_b = sum_b + bb3_pkg::SUM_W'(cols[k][r].blue);
                end
            end
        end
        row_n = 2'd1 + {1'b0, s1.top} + {1'b0, s1.bot};
        col_n = 2'd1 + {1'b0, s1.lft} + {1'b0, s1.rgt};
        cnt   = {2'b00, row_n} * {2'b00, col_n};
    end

    always_comb
    begin
        s2_next.valid = s1.valid && s1.emit;
        s2_next.num_r = {sum_r, 1'b0} + bb3_pkg::NUM_W'(cnt);
        s2_next.num_g = {sum_g, 1'b0} + bb3_pkg::NUM_W'(cnt);
        s2_next.num_b = {sum_b, 1'b0} + bb3_pkg::NUM_W'(cnt);
        s2_next.count = cnt;
        s2_next.last  = s1.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col0_reg      <= '0;
            col1_reg      <= '0;
            fwd_valid_reg <= 1'b0;
            s2_reg        <= '0;
        end
        else if (en)
        begin
            fwd_valid_reg <= fwd_valid_next;
            s2_reg        <= s2_next;
            if (s1.valid)
            begin
                col0_reg <= col1_reg;
                col1_reg <= col2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign s2 = s2_reg;

    // a forward is only pending for an item that sits in this stage
    a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1.valid)
        else $error("forwarded line data without an item in the window stage");

    a_emit_reaches_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (en && s1.valid && s1.emit) |=> s2_reg.valid)
        else $error("emitting item lost between window and divide stages");

endmodule

[rtl/bb3_divide.sv]
// bb3_divide: divide stage and output register. Divides each rounding numerator by
// 2*count with a reciprocal multiply. Depends on bb3_pkg.
module bb3_divide (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  bb3_pkg::s2_t   s2,
    output logic           out_valid,
    output bb3_pkg::pixel_t out_pix,
    output logic           out_last
);

    localparam int K = bb3_pkg::RECIP_SHIFT;

    logic [bb3_pkg::RECIP_W-1:0] m;
    logic [bb3_pkg::PROD_W-1:0]  prod_r;
    logic [bb3_pkg::PROD_W-1:0]  prod_g;
    logic [bb3_pkg::PROD_W-1:0]  prod_b;
    logic                        out_valid_reg;
    bb3_pkg::pixel_t             out_pix_reg;
    logic                        out_last_reg;

    assign m      = bb3_pkg::recip(s2.count);
    assign prod_r = bb3_pkg::PROD_W'(s2.num_r) * bb3_pkg::PROD_W'(m);
    assign prod_g = bb3_pkg::PROD_W'(s2.num_g) * bb3_pkg::PROD_W'(m);
    assign prod_b = bb3_pkg::PROD_W'(s2.num_b) * bb3_pkg::PROD_W'(m);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s2.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pix_reg.red   <= prod_r[K+7:K];
            out_pix_reg.green <= prod_g[K+7:K];
            out_pix_reg.blue  <= prod_b[K+7:K];
            out_last_reg      <= s2.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_last  = out_last_reg;

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        s2.valid |-> (s2.count == 4'd1 || s2.count == 4'd2 || s2.count == 4'd3 ||
                      s2.count == 4'd4 || s2.count == 4'd6 || s2.count == 4'd9))
        else $error("neighbourhood count outside the reciprocal table");

endmodule

[bench/box_blur_tb_pkg.sv]
// box_blur_tb_pkg: item mode codes and spare register indexes shared by the bench files.
// Depends on bb3_pkg for the register index width.
package box_blur_tb_pkg;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } item_mode_t;

    // indexes that decode to no register
    localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = bb3_pkg::CFG_IDX_W'(2);
    localparam logic [bb3_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = bb3_pkg::CFG_IDX_W'(3);

endpackage

[bench/box_blur_checker.sv]
// box_blur_checker: watches the cfg, pixel-in and pixel-out channels of the 3x3 RGB blur,
// predicts every blurred pixel and compares it with what the block sends.
// Depends on bb3_pkg, box_blur_tb_pkg and the three channel interfaces.
module box_blur_checker
    import bb3_pkg::*;
    import box_blur_tb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bb3_cfg_if   cfg,
    bb3_in_if    pix_in,
    bb3_out_if   pix_out,
    output int   mismatches,
    output int   pending_results
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        pixel_t pix;
        logic   last;
    } blurred_t;

    pixel_t      upper_line  [MAX_WIDTH];
    pixel_t      middle_line [MAX_WIDTH];
    column_t     win_cols    [2];
    int unsigned frame_w, frame_h;
    int unsigned in_row, in_col, out_row, out_col;
    blurred_t    expected_pixels [$];

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task restart_positions();
        in_row  = 0;
        in_col  = 0;
        out_row = 0;
        out_col = 0;
    endtask

    // one accepted transaction: may release the blurred pixel one row and one pixel back
    task automatic blur_step(input logic mode, input pixel_t px);
        column_t     cols [3];
        pixel_t      pix;
        logic [23:0] acc, v;
        int unsigned c, pos, count, sum, sh;
        logic        top, bot, lft, rgt, fin;
        blurred_t    res;
        pix = px;
        fin = 1'b0;
        if (in_row < frame_h) begin
            if (mode == MODE_DRAIN)
                return;
        end
        else
            pix = '0;
        c = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
        cols[0]    = win_cols[0];
        cols[1]    = win_cols[1];
        cols[2][0] = upper_line[c];
        cols[2][1] = middle_line[c];
        cols[2][2] = pix;
        pos = in_row * frame_w + in_col;
        if (pos >= frame_w + 1) begin
            top   = out_row > 0;
            bot   = out_row + 1 < frame_h;
            lft   = out_col > 0;
            rgt   = out_col + 1 < frame_w;
            count = (1 + (top ? 1 : 0) + (bot ? 1 : 0)) * (1 + (lft ? 1 : 0) + (rgt ? 1 : 0));
            acc   = '0;
            for (int ch = 0; ch < 3; ch++) begin
                sh  = 16 - 8 * ch;
                sum = 0;
                for (int k = 0; k < 3; k++)
                    for (int r = 0; r < 3; r++)
                        if (!((k == 0 && !lft) || (k == 2 && !rgt) ||
                              (r == 0 && !top) || (r == 2 && !bot)))
                        begin
                            v   = cols[k][r];
                            sum += (v >> sh) & 24'hFF;
                        end
                // half-up rounding of sum/count
                acc[sh +: 8] = 8'((2 * sum + count) / (2 * count));
            end
            res.pix  = acc;
            res.last = (out_row == frame_h - 1) && (out_col == frame_w - 1);
            fin      = res.last;
            expected_pixels.push_back(res);
            out_col++;
            if (out_col >= frame_w) begin
                out_col = 0;
                out_row++;
            end
        end
        upper_line[c]  = middle_line[c];
        middle_line[c] = pix;
        win_cols[0]    = cols[1];
        win_cols[1]    = cols[2];
        in_col++;
        if (in_col >= frame_w) begin
            in_col = 0;
            in_row++;
        end
        if (fin)
            restart_positions();
    endtask

    always @(posedge clk or negedge rst_n) begin : monitor
        blurred_t want, got;
        if (!rst_n) begin
            frame_w     = RESET_WIDTH;
            frame_h     = RESET_HEIGHT;
            win_cols[0] = '0;
            win_cols[1] = '0;
            restart_positions();
            expected_pixels.delete();
            pending_results <= 0;
        end
        else begin
            // results first: nothing accepted at this edge can come out at the same edge
            if (pix_out.valid && pix_out.ready) begin
                got.pix  = {pix_out.out_red, pix_out.out_green, pix_out.out_blue};
                got.last = pix_out.last_of_frame;
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: blurred pixel, expected none, actual r=%0d g=%0d b=%0d last=%0b",
                                 $time, got.pix.red, got.pix.green, got.pix.blue, got.last);
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: blurred pixel, expected r=%0d g=%0d b=%0d last=%0b, actual r=%0d g=%0d b=%0d last=%0b",
                                     $time, want.pix.red, want.pix.green, want.pix.blue, want.last,
                                     got.pix.red, got.pix.green, got.pix.blue, got.last);
                    end
                end
            end
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == REG_FRAME_WIDTH) begin
                    frame_w = clamp_dim(cfg.data[FW_FIELD_W-1:0], MAX_WIDTH);
                    restart_positions();
                end
                else if (cfg.index == REG_FRAME_HEIGHT) begin
                    frame_h = clamp_dim(cfg.data[FH_FIELD_W-1:0], MAX_HEIGHT);
                    restart_positions();
                end
            end
            if (pix_in.valid && pix_in.ready)
                blur_step(pix_in.mode, {pix_in.in_red, pix_in.in_green, pix_in.in_blue});
            pending_results <= expected_pixels.size();
        end
    end

endmodule

[bench/tb_box_blur_3x3_rgb.sv]
// tb_box_blur_3x3_rgb: stimulus and verdict for the 3x3 RGB box blur; frames of many
// sizes with random pixel data, drains, idle bursts and back-pressure.
// Depends on bb3_pkg, box_blur_tb_pkg, the channel interfaces, box_blur_checker, the RTL.
module tb_box_blur_3x3_rgb;
    import bb3_pkg::*;
    import box_blur_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_ITEMS  = 150;
    localparam int PIPE_SLACK   = 16;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PARTIAL_ROW  = 40;
    localparam int TALL_ROWS    = 64;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    item_mode_t            in_mode  = MODE_PIXEL;
    pixel_t                in_pix   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    gap_pct    = 0;
    int                    stall_pct  = 0;
    int                    stall_left = 0;
    int                    cycle_count = 0;
    int unsigned           sent_items = 0;
    int                    mismatches;
    int                    pending_results;

    bb3_cfg_if cfg_bus ();
    bb3_in_if  pix_in_bus ();
    bb3_out_if pix_out_bus ();

    assign cfg_bus.valid        = cfg_valid;
    assign cfg_bus.index        = cfg_index;
    assign cfg_bus.data         = cfg_data;
    assign pix_in_bus.valid     = in_valid;
    assign pix_in_bus.mode      = in_mode;
    assign pix_in_bus.in_red    = in_pix.red;
    assign pix_in_bus.in_green  = in_pix.green;
    assign pix_in_bus.in_blue   = in_pix.blue;
    assign pix_out_bus.ready    = out_ready;

    box_blur_3x3_rgb u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_bus),
        .pix_in  (pix_in_bus),
        .pix_out (pix_out_bus)
    );

    box_blur_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_bus),
        .pix_in          (pix_in_bus),
        .pix_out         (pix_out_bus),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("box_blur_3x3_rgb: mismatch");
            $finish;
        end
    end

    // receiver back-pressure: stall bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (int'($urandom_range(99)) < stall_pct) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(7, 0);
        end
        else
            out_ready <= 1'b1;
    end

    function automatic pixel_t noise_pixel();
        logic [31:0] r;
        pixel_t      p;
        r = $urandom;
        p = r[23:0];
        case ($urandom_range(9))
            0:       p = '0;
            1:       p = '1;
            2:       p.green = 8'hFF;
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_item(input item_mode_t m, input pixel_t p);
        if (int'($urandom_range(99)) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_mode  <= m;
        in_pix   <= p;
        @(posedge clk);
        while (!pix_in_bus.ready) @(posedge clk);
    endtask

    // hold keeps valid up for a back-to-back write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit hold);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
        if (!hold)
            cfg_valid <= 1'b0;
    endtask

    // wait until every expected pixel is out, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (PIPE_SLACK) @(posedge clk);
    endtask

    // stop_at below w*h abandons the frame; spare_at >= 0 pauses for a no-op register write
    task automatic run_frame(input int unsigned w, input int unsigned h,
                             input int unsigned stop_at, input int spare_at);
        for (int unsigned i = 0; i < stop_at; i++) begin
            if (int'(i) == spare_at) begin
                settle();
                write_reg(($urandom_range(1) != 0) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom), 1'b0);
            end
            // drain inside a frame is dropped by the block
            if ($urandom_range(99) < 4)
                send_item(MODE_DRAIN, noise_pixel());
            send_item(MODE_PIXEL, noise_pixel());
        end
        sent_items += stop_at;
        if (stop_at == w * h) begin
            // a pixel while draining counts as a drain
            for (int unsigned i = 0; i <= w; i++) begin
                if ($urandom_range(99) < 30)
                    send_item(MODE_PIXEL, noise_pixel());
                else
                    send_item(MODE_DRAIN, noise_pixel());
            end
            sent_items += w + 1;
            if ($urandom_range(99) < 5)
                send_item(MODE_DRAIN, noise_pixel());
        end
    endtask

    initial
    begin : stimulus
        pixel_t                pattern [9];
        int unsigned           fw, fh, w_raw, h_raw, pixels, stop, pick;
        int                    spare;
        bit                    need_write;
        logic [CFG_DATA_W-1:0] wd;
        pattern = '{24'hFFFFFF, 24'h000100, 24'hFF0001, 24'h000000, 24'h00FF00,
                    24'hFFFFFF, 24'h0000FF, 24'hFF0000, 24'h010101};
        fw = 1;
        fh = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: a short stretch of a full-width row releases nothing
        gap_pct   = 10;
        stall_pct = 10;
        run_frame(RESET_WIDTH, RESET_HEIGHT, PARTIAL_ROW, -1);

        // 3x3 frame, every position a distinct border case; width upper bits are ignored
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(13'h1003), 1'b1);
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3), 1'b0);
        for (int i = 0; i < 9; i++) begin
            if (i == 4)
                send_item(MODE_DRAIN, pattern[0]);
            send_item(MODE_PIXEL, pattern[i]);
        end
        send_item(MODE_PIXEL, 24'hFFFFFF);
        repeat (3) send_item(MODE_DRAIN, 24'h000000);

        // zero sizes clamp to a 1x1 frame
        settle();
        write_reg(REG_FRAME_WIDTH, '0, 1'b1);
        write_reg(REG_FRAME_HEIGHT, '0, 1'b0);
        send_item(MODE_PIXEL, 24'hFF0080);
        send_item(MODE_DRAIN, 24'h000000);
        send_item(MODE_PIXEL, 24'h123456);

        // oversized values saturate; then a frame abandoned midway
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2 ** FW_FIELD_W - 1), 1'b1);
        write_reg(REG_FRAME_HEIGHT, '1, 1'b1);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2), 1'b0);
        run_frame(2, MAX_HEIGHT, 20, 10);

        // tallest frame, one column, first rows only
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(13'h1801), 1'b1);
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(MAX_HEIGHT), 1'b0);
        run_frame(1, MAX_HEIGHT, TALL_ROWS, -1);

        sent_items = 0;
        need_write = 1'b1;
        while (sent_items < RANDOM_ITEMS) begin
            if (sent_items + QUIET_ITEMS >= RANDOM_ITEMS) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else begin
                gap_pct   = 10 * $urandom_range(4);
                stall_pct = 10 * $urandom_range(4);
            end
            if (need_write || $urandom_range(99) < 60) begin
                pick = $urandom_range(99);
                if (pick < 5)
                    w_raw = 0;
                else if (pick < 70)
                    w_raw = $urandom_range(8, 1);
                else if (pick < 95)
                    w_raw = $urandom_range(32, 9);
                else
                    w_raw = $urandom_range(96, 33);
                pick = $urandom_range(99);
                if (pick < 5)
                    h_raw = 0;
                else if (pick < 80)
                    h_raw = $urandom_range(6, 1);
                else
                    h_raw = $urandom_range(20, 7);
                wd = CFG_DATA_W'($urandom);
                wd[FW_FIELD_W-1:0] = w_raw[FW_FIELD_W-1:0];
                settle();
                write_reg(REG_FRAME_WIDTH, wd, 1'b1);
                write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h_raw), 1'b0);
                fw = (w_raw == 0) ? 1 : w_raw;
                fh = (h_raw == 0) ? 1 : h_raw;
            end
            pixels = fw * fh;
            stop   = ($urandom_range(99) < 10) ? $urandom_range(pixels - 1) : pixels;
            // keep the item total near the target
            if (stop > RANDOM_ITEMS - sent_items)
                stop = RANDOM_ITEMS - sent_items;
            spare  = ($urandom_range(99) < 5 && stop > 0) ? int'($urandom_range(stop - 1)) : -1;
            need_write = stop < pixels;
            run_frame(fw, fh, stop, spare);
        end

        settle();
        if (mismatches == 0 && pending_results == 0)
            $display("box_blur_3x3_rgb: match");
        else
            $display("box_blur_3x3_rgb: mismatch");
        $finish;
    end

endmodule
